// ===== rtl/ijs_pkg.sv =====
// Shared constants, codes and types for the interval jitter statistics block.
// Depends on nothing; every other file but the checker refers to it by scoped names.
package ijs_pkg;

    localparam int MAX_INTERVALS = 256;
    localparam int ADDR_W        = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS) + 1;
    localparam int IV_W          = 24;
    localparam int TIME_W        = 32;
    localparam int SUM_W         = 32;
    localparam int ACC_W         = 72;
    localparam int RATE_W        = 28;
    localparam int STEP_W        = 7;

    localparam logic [IV_W-1:0]   INTERVAL_MAX = {IV_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};
    // One million microseconds per second, times 256 for the Q20.8 result.
    localparam logic [RATE_W-1:0] US_SCALE     = 28'd256000000;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_CYCLE = 2'd2;

    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

// ===== rtl/ijs_store.sv =====
// Interval store: one write port and one registered read port.
// Depends on ijs_pkg for depth and widths.
module ijs_store (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [ijs_pkg::ADDR_W-1:0] waddr,
    input  logic [ijs_pkg::IV_W-1:0]   wdata,
    input  logic [ijs_pkg::ADDR_W-1:0] raddr,
    output logic [ijs_pkg::IV_W-1:0]   rdata
);

    logic [ijs_pkg::IV_W-1:0] mem [ijs_pkg::MAX_INTERVALS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ijs_seq_unit.sv =====
// Shared iterative unit: restoring division (one quotient bit a cycle) and
// integer square root (one root bit a cycle) on a single 37-bit subtractor.
// Depends on ijs_pkg.
module ijs_seq_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ijs_pkg::unit_req_t         req,
    input  logic [ijs_pkg::ACC_W-1:0]  operand,
    input  logic [ijs_pkg::SUM_W-1:0]  divisor,
    output ijs_pkg::unit_sts_t         sts,
    output logic [ijs_pkg::ACC_W-1:0]  result
);

    logic                      busy_reg;
    logic                      done_reg;
    logic                      mode_reg;
    logic [ijs_pkg::STEP_W-1:0] cnt_reg;
    logic [ijs_pkg::ACC_W-1:0] a_reg;
    logic [35:0]               rem_reg;
    logic [31:0]               div_reg;
    logic [31:0]               root_reg;

    logic [32:0] rem_sh_div;
    logic [35:0] rem_sh_sqrt;
    logic [35:0] opa;
    logic [35:0] opb;
    logic [36:0] diff;
    logic        ge;

    always_comb begin
        rem_sh_div  = {rem_reg[31:0], a_reg[ijs_pkg::ACC_W-1]};
        rem_sh_sqrt = {rem_reg[33:0], a_reg[63:62]};
        if (mode_reg == ijs_pkg::MODE_SQRT) begin
            opa = rem_sh_sqrt;
            opb = {2'b00, root_reg, 2'b01};
        end else begin
            opa = {3'b000, rem_sh_div};
            opb = {4'b0000, div_reg};
        end
        diff = {1'b0, opa} - {1'b0, opb};
        ge   = ~diff[36];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                a_reg    <= operand;
                div_reg  <= divisor;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= (req.mode == ijs_pkg::MODE_SQRT) ? 7'd31 : 7'd71;
            end else if (busy_reg) begin
                if (mode_reg == ijs_pkg::MODE_SQRT) begin
                    rem_reg  <= ge ? diff[35:0] : rem_sh_sqrt;
                    root_reg <= {root_reg[30:0], ge};
                    a_reg    <= {a_reg[ijs_pkg::ACC_W-3:0], 2'b00};
                end else begin
                    rem_reg  <= {4'b0000, (ge ? diff[31:0] : rem_sh_div[31:0])};
                    a_reg    <= {a_reg[ijs_pkg::ACC_W-2:0], ge};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = (mode_reg == ijs_pkg::MODE_SQRT) ? {40'd0, root_reg} : a_reg;

endmodule

// ===== rtl/interval_jitter_statistics.sv =====
// A start mark, or an end mark that does not complete a round, is taken while idle.
// A completing request makes two passes over the store's single read port (sum, then
// squared deviations) and uses the shared bit-serial divide and square root unit for
// mean, variance, standard deviation and rate, plus any wait for the previous result
// to leave; s_tready stays low meanwhile. Reset (aresetn low, synchronous) clears the
// count, start flag and output; the register returns to 256, store contents undefined.
module interval_jitter_statistics (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // time_us [31:0]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // mean_q8 [31:0], std_dev_q8 [63:32], rate_q8 [91:64]
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SUM  = 4'd1;
    localparam logic [3:0] ST_MEAN = 4'd2;
    localparam logic [3:0] ST_SQ   = 4'd3;
    localparam logic [3:0] ST_VAR  = 4'd4;
    localparam logic [3:0] ST_SQRT = 4'd5;
    localparam logic [3:0] ST_RATE = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;

    localparam int CW = ijs_pkg::CNT_W;
    localparam logic [27:0] US_SCALE_EXT = ijs_pkg::US_SCALE;

    logic [3:0]                     state_reg, state_next;
    logic [8:0]                     cfg_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  n_reg;
    logic [CW-1:0]                  idx_reg;
    logic [31:0]                    stamp_reg;
    logic                           sv_reg;
    logic                           p1_reg, p2_reg, p3_reg;
    logic                           go_reg;
    logic [ijs_pkg::SUM_W-1:0]      sum_reg;
    logic [ijs_pkg::ACC_W-1:0]      sumsq_reg;
    logic [31:0]                    mean_reg;
    logic [31:0]                    d_reg;
    logic [63:0]                    sq_reg;
    logic [63:0]                    var_reg;
    logic [31:0]                    sd_reg;
    logic [ijs_pkg::RATE_W-1:0]     rate_reg;
    logic                           m_tvalid_reg;
    logic [95:0]                    m_tdata_reg;

    logic [CW-1:0]                  n_eff;
    logic                           accept;
    logic                           is_end;
    logic                           is_start;
    logic                           do_store;
    logic [CW-1:0]                  cnt_new;
    logic                           issue;
    logic [ijs_pkg::IV_W-1:0]       rdata;
    logic [31:0]                    iv_raw;
    logic [ijs_pkg::IV_W-1:0]       iv_sat;
    logic [31:0]                    x_q8;
    logic                           out_free;
    logic [36:0]                    rate_num;

    ijs_pkg::unit_req_t             ureq;
    ijs_pkg::unit_sts_t             usts;
    logic [ijs_pkg::ACC_W-1:0]      u_operand;
    logic [ijs_pkg::SUM_W-1:0]      u_divisor;
    logic [ijs_pkg::ACC_W-1:0]      u_result;

    always_comb begin
        if (cfg_reg < 9'd2) begin
            n_eff = 9'd2;
        end else if (cfg_reg > 9'(ijs_pkg::MAX_INTERVALS)) begin
            n_eff = CW'(ijs_pkg::MAX_INTERVALS);
        end else begin
            n_eff = cfg_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_end   = (s_tuser == ijs_pkg::ACT_END) || (s_tuser == ijs_pkg::ACT_CYCLE);
    assign is_start = (s_tuser == ijs_pkg::ACT_START) || (s_tuser == ijs_pkg::ACT_CYCLE);
    assign iv_raw   = s_tdata - stamp_reg;
    assign iv_sat   = (|iv_raw[31:ijs_pkg::IV_W]) ? ijs_pkg::INTERVAL_MAX
                                                  : iv_raw[ijs_pkg::IV_W-1:0];
    assign do_store = accept && is_end && sv_reg
                      && (count_reg < CW'(ijs_pkg::MAX_INTERVALS));
    assign cnt_new  = count_reg + CW'(do_store);
    assign issue    = ((state_reg == ST_SUM) || (state_reg == ST_SQ)) && (idx_reg < n_reg);
    assign x_q8     = {rdata, 8'd0};
    assign out_free = !m_tvalid_reg || m_tready;
    assign rate_num = n_reg * US_SCALE_EXT;

    ijs_store u_store (
        .aclk  (aclk),
        .we    (do_store),
        .waddr (count_reg[ijs_pkg::ADDR_W-1:0]),
        .wdata (iv_sat),
        .raddr (idx_reg[ijs_pkg::ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        ureq.start = 1'b0;
        ureq.mode  = ijs_pkg::MODE_DIV;
        u_operand  = '0;
        u_divisor  = '0;
        case (state_reg)
            ST_MEAN: begin
                ureq.start = !go_reg;
                u_operand  = {32'd0, sum_reg, 8'd0};
                u_divisor  = {23'd0, n_reg};
            end
            ST_VAR: begin
                ureq.start = !go_reg;
                u_operand  = sumsq_reg;
                u_divisor  = {23'd0, n_reg - 9'd1};
            end
            ST_SQRT: begin
                ureq.start = !go_reg;
                ureq.mode  = ijs_pkg::MODE_SQRT;
                u_operand  = {8'd0, var_reg};
            end
            ST_RATE: begin
                ureq.start = !go_reg;
                u_operand  = {35'd0, rate_num};
                u_divisor  = sum_reg;
            end
            default: begin
                ureq.start = 1'b0;
            end
        endcase
    end

    ijs_seq_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .operand (u_operand),
        .divisor (u_divisor),
        .sts     (usts),
        .result  (u_result)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && is_end && (cnt_new >= n_eff)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (!issue && !p1_reg) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (usts.done) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (!issue && !p1_reg && !p2_reg && !p3_reg) begin
                    state_next = ST_VAR;
                end
            end
            ST_VAR: begin
                if (usts.done) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (usts.done) begin
                    state_next = (sum_reg == '0) ? ST_OUT : ST_RATE;
                end
            end
            ST_RATE: begin
                if (usts.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= 9'd256;
            count_reg    <= '0;
            sv_reg       <= 1'b0;
            stamp_reg    <= '0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            p3_reg       <= 1'b0;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end

            if (accept) begin
                // A cycle mark ends the open interval and opens the next one.
                if (is_end || is_start) begin
                    sv_reg <= is_start;
                end
                if (is_end) begin
                    count_reg <= (cnt_new >= n_eff) ? '0 : cnt_new;
                    if (cnt_new >= n_eff) begin
                        n_reg     <= n_eff;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        sumsq_reg <= '0;
                    end
                end
                if (is_start) begin
                    stamp_reg <= s_tdata;
                end
            end

            // Read pipeline of the two store passes: address, data, deviation, square.
            p1_reg <= issue;
            p2_reg <= p1_reg && (state_reg == ST_SQ);
            p3_reg <= p2_reg;
            if (issue) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (p1_reg && (state_reg == ST_SUM)) begin
                sum_reg <= sum_reg + {8'd0, rdata};
            end
            if (p1_reg && (state_reg == ST_SQ)) begin
                d_reg <= (x_q8 >= mean_reg) ? (x_q8 - mean_reg) : (mean_reg - x_q8);
            end
            if (p2_reg) begin
                sq_reg <= d_reg * d_reg;
            end
            if (p3_reg) begin
                sumsq_reg <= sumsq_reg + {8'd0, sq_reg};
            end

            if (usts.done) begin
                go_reg <= 1'b0;
            end else if (ureq.start) begin
                go_reg <= 1'b1;
            end
            if (usts.done) begin
                case (state_reg)
                    ST_MEAN: begin
                        mean_reg <= u_result[31:0];
                        idx_reg  <= '0;
                    end
                    ST_VAR: begin
                        var_reg <= (|u_result[71:64]) ? '1 : u_result[63:0];
                    end
                    ST_SQRT: begin
                        sd_reg   <= u_result[31:0];
                        rate_reg <= ijs_pkg::RATE_MAX;
                    end
                    ST_RATE: begin
                        rate_reg <= (|u_result[71:28]) ? ijs_pkg::RATE_MAX : u_result[27:0];
                    end
                    default: begin
                    end
                endcase
            end

            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {4'd0, rate_reg, sd_reg, mean_reg};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/ijs_checker.sv =====
// Port-level checks for interval_jitter_statistics, attached by bind.
// Depends only on the top level's ports.
module ijs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A result only appears after the block has been busy computing it.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a computation");

    // Intervals are capped at 24 bits, so the rate can never fall to zero.
    a_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[91:64] != 28'd0))
        else $error("rate of zero reported");

    // The mean of 24-bit intervals in Q24.8 has an upper bound.
    a_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:0] <= 32'hFFFFFF00))
        else $error("mean out of range");

endmodule

bind interval_jitter_statistics ijs_checker u_ijs_checker (.*);
